// ----- sv/lcdspc_pkg.sv -----
package lcdspc_pkg;

    // Mask depth modes; the unused code 3 falls back to eight-bit codes.
    localparam logic [1:0] DEPTH_8BIT = 2'd0;
    localparam logic [1:0] DEPTH_4BIT = 2'd1;
    localparam logic [1:0] DEPTH_2BIT = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_DEPTH_MODE       = 1'b0;
    localparam logic CFG_TRANSPARENT_CODE = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [1:0] DEPTH_MODE_RESET       = DEPTH_8BIT;
    localparam logic [7:0] TRANSPARENT_CODE_RESET = 8'hFF;

    // A two-bit code of zero multiplies as this value.
    localparam logic [7:0] ZERO_CODE_SUBST = 8'd39;

    // RGB565 channel positions.
    localparam int RED_LSB   = 11;
    localparam int GREEN_LSB = 5;

    // Live configuration seen by the shading logic.
    typedef struct packed {
        logic [1:0] depth_mode;
        logic [7:0] transparent_code;
    } cfg_t;

    // One input pixel as it sits in the input register.
    typedef struct packed {
        logic [15:0] source_pixel;
        logic        segment_on;
        logic [1:0]  sub_position;
        logic [7:0]  mask_byte;
    } pix_in_t;

    // One result pixel.
    typedef struct packed {
        logic        write_enable;
        logic [15:0] pixel_out;
    } pix_out_t;

endpackage

// ----- sv/lcdspc_shade.sv -----
module lcdspc_shade
    import lcdspc_pkg::*;
(
    input  cfg_t     cfg,
    input  pix_in_t  pix_in,
    output pix_out_t pix_out
);

    logic [1:0]  code2;
    logic [3:0]  code4;
    logic [7:0]  code;
    logic [7:0]  mult;
    logic        hit;
    logic [12:0] red_prod;
    logic [13:0] green_prod;
    logic [12:0] blue_prod;

    // Expand the mask code to eight bits according to the depth mode.
    always_comb
    begin
        code2 = 2'(pix_in.mask_byte >> {pix_in.sub_position, 1'b0});
        code4 = pix_in.sub_position[0] ? pix_in.mask_byte[3:0] : pix_in.mask_byte[7:4];
        unique case (cfg.depth_mode)
            DEPTH_2BIT: code = {code2, code2, code2, code2};
            DEPTH_4BIT: code = {code4, code4};
            default:    code = pix_in.mask_byte;
        endcase
    end

    // The transparency test uses the expanded code; the zero substitution comes after.
    assign hit  = pix_in.segment_on && (code != cfg.transparent_code);
    assign mult = ((cfg.depth_mode == DEPTH_2BIT) && (code == 8'd0)) ? ZERO_CODE_SUBST : code;

    // Scale each channel by the code and drop the low eight bits.
    assign red_prod   = 13'(pix_in.source_pixel[15:RED_LSB]) * 13'(mult);
    assign green_prod = 14'(pix_in.source_pixel[RED_LSB-1:GREEN_LSB]) * 14'(mult);
    assign blue_prod  = 13'(pix_in.source_pixel[GREEN_LSB-1:0]) * 13'(mult);

    // A pixel that is not written carries zero data.
    always_comb
    begin
        pix_out.write_enable = hit;
        if (hit)
        begin
            pix_out.pixel_out = {red_prod[12:8], green_prod[13:8], blue_prod[12:8]};
        end
        else
        begin
            pix_out.pixel_out = 16'd0;
        end
    end

endmodule

// ----- sv/lcd_segment_pixel_compositor_top.sv -----
// Path: an accepted input beat is held in the input register and its result in the
// result register. Throughput: one pixel per cycle while m_tready does not stall the
// output; each register holds one beat, the three channel multipliers between them.
// Reset: rst_n is asynchronous and active low; it empties both stages and sets
// depth_mode to eight-bit codes and transparent_code to 255.
module lcd_segment_pixel_compositor_top
    import lcdspc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,

    // Input pixel stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // mask_byte[7:0], sub_position[9:8], segment_on[10],
                                   // source_pixel[26:11], zero[31:27]

    // Result pixel stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pixel_out[15:0]
    output logic        m_tuser    // write_enable[0]
);

    cfg_t     cfg_reg;
    logic     in_valid_reg;
    pix_in_t  in_reg;
    logic     out_valid_reg;
    pix_out_t out_reg;
    pix_out_t shade_out;
    logic     in_ready;
    logic     out_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_mode       <= DEPTH_MODE_RESET;
            cfg_reg.transparent_code <= TRANSPARENT_CODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_DEPTH_MODE:       cfg_reg.depth_mode       <= cfg_wdata[1:0];
                CFG_TRANSPARENT_CODE: cfg_reg.transparent_code <= cfg_wdata;
                default:              cfg_reg.transparent_code <= cfg_wdata;
            endcase
        end
    end

    // Each stage moves when it is empty or its contents move on.
    assign out_ready = !out_valid_reg || m_tready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign s_tready  = in_ready;

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_tvalid)
        begin
            in_reg <= pix_in_t'(s_tdata[26:0]);
        end
    end

    lcdspc_shade u_shade (
        .cfg     (cfg_reg),
        .pix_in  (in_reg),
        .pix_out (shade_out)
    );

    // Result register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && in_valid_reg)
        begin
            out_reg <= shade_out;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.pixel_out;
    assign m_tuser  = out_reg.write_enable;

endmodule

// ----- bench/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdspc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_PHASE_BEATS = 125;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = CFG_DEPTH_MODE;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    // Local copy of the configuration registers.
    logic [1:0]  depth_now = DEPTH_MODE_RESET;
    logic [7:0]  transp_now = TRANSPARENT_CODE_RESET;

    // Shaded pixels still owed by the block, oldest first.
    pix_out_t    shade_q[$];
    pix_out_t    owed_pix;

    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    int          stall_left = 0;
    bit          idle_on = 1'b1;

    lcd_segment_pixel_compositor_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 clk = ~clk;

    // Expand the mask code for the current depth and darken the source pixel with it.
    function automatic pix_out_t shade_pixel(input pix_in_t px);
        logic [1:0]  pair;
        logic [3:0]  nib;
        logic [7:0]  code;
        logic [7:0]  mult;
        logic [12:0] red_prod;
        logic [13:0] green_prod;
        logic [12:0] blue_prod;
        pix_out_t    res;
        case (depth_now)
            DEPTH_2BIT:
            begin
                pair = 2'(px.mask_byte >> (2 * px.sub_position));
                code = {4{pair}};
            end
            DEPTH_4BIT:
            begin
                nib  = px.sub_position[0] ? px.mask_byte[3:0] : px.mask_byte[7:4];
                code = {nib, nib};
            end
            default:
            begin
                code = px.mask_byte;
            end
        endcase
        res = '0;
        if (px.segment_on && code != transp_now)
        begin
            // The transparency test has already seen the raw expanded code.
            mult = (depth_now == DEPTH_2BIT && code == 8'd0) ? ZERO_CODE_SUBST : code;
            red_prod   = 13'(px.source_pixel[15:11]) * 13'(mult);
            green_prod = 14'(px.source_pixel[10:5]) * 14'(mult);
            blue_prod  = 13'(px.source_pixel[4:0]) * 13'(mult);
            res.write_enable = 1'b1;
            res.pixel_out = {red_prod[12:8], green_prod[13:8], blue_prod[12:8]};
        end
        return res;
    endfunction

    // Gap length: mostly none, often short, rarely long.
    function automatic int pick_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Offer one pixel beat and record its shaded result once it is taken.
    task automatic send_pixel(input logic [7:0] mask, input logic [1:0] pos,
                              input logic on, input logic [15:0] src);
        int      gap;
        pix_in_t px;
        px.mask_byte    = mask;
        px.sub_position = pos;
        px.segment_on   = on;
        px.source_pixel = src;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, px};
        do
            @(posedge clk);
        while (!s_tready);
        shade_q.push_back(shade_pixel(px));
    endtask

    // Stop offering beats and wait until every owed result has come back.
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (shade_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write; the block must be idle.
    task automatic write_reg(input logic addr, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == CFG_DEPTH_MODE)
            depth_now = data[1:0];
        else
            transp_now = data;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [1:0] depth, input logic [7:0] transp);
        drain_pipe();
        write_reg(CFG_DEPTH_MODE, {6'($urandom_range(0, 63)), depth});
        write_reg(CFG_TRANSPARENT_CODE, transp);
    endtask

    // Eight-bit codes with the reset configuration, including the extremes.
    task automatic test_reset_defaults();
        send_pixel(8'hFF, 2'd0, 1'b1, 16'hFFFF);
        send_pixel(8'hFE, 2'd3, 1'b1, 16'hFFFF);
        send_pixel(8'h00, 2'd1, 1'b1, 16'hFFFF);
        send_pixel(8'h80, 2'd2, 1'b1, 16'h0000);
        send_pixel(8'hFE, 2'd0, 1'b0, 16'hFFFF);
        send_pixel(8'h55, 2'd0, 1'b1, 16'hA5C3);
    endtask

    // Nibble and pair extraction, the zero-code substitute and the unused mode.
    task automatic test_depth_modes();
        set_config(DEPTH_4BIT, 8'hFF);
        send_pixel(8'h3C, 2'd0, 1'b1, 16'hFFFF);
        send_pixel(8'h3C, 2'd1, 1'b1, 16'hFFFF);
        send_pixel(8'hF0, 2'd2, 1'b1, 16'hFFFF);
        send_pixel(8'hF0, 2'd3, 1'b1, 16'hFFFF);
        send_pixel(8'h0F, 2'd3, 1'b1, 16'hFFFF);
        set_config(DEPTH_2BIT, 8'hAA);
        send_pixel(8'b11100100, 2'd0, 1'b1, 16'hFFFF);
        send_pixel(8'b11100100, 2'd1, 1'b1, 16'hFFFF);
        send_pixel(8'b11100100, 2'd2, 1'b1, 16'hFFFF);
        send_pixel(8'b11100100, 2'd3, 1'b1, 16'hFFFF);
        send_pixel(8'h00, 2'd2, 1'b0, 16'hFFFF);
        // A zero pair equal to the transparent code stays unwritten.
        set_config(DEPTH_2BIT, 8'h00);
        send_pixel(8'h00, 2'd0, 1'b1, 16'hFFFF);
        send_pixel(8'h01, 2'd0, 1'b1, 16'hFFFF);
        set_config(2'd3, 8'h00);
        send_pixel(8'h00, 2'd2, 1'b1, 16'hFFFF);
        send_pixel(8'hFF, 2'd1, 1'b1, 16'hFFFF);
        send_pixel(8'h0F, 2'd0, 1'b1, 16'h0000);
    endtask

    // Transparent codes that the current depth can actually produce.
    function automatic logic [7:0] reachable_code(input logic [1:0] depth);
        logic [3:0] nib;
        logic [1:0] pair;
        nib  = 4'($urandom_range(0, 15));
        pair = 2'($urandom_range(0, 3));
        case (depth)
            DEPTH_4BIT: return {nib, nib};
            DEPTH_2BIT: return {4{pair}};
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_random_phase(input logic [1:0] depth, input logic [7:0] transp,
                                    input bit idle, input int count);
        logic [7:0]  mask;
        logic [15:0] src;
        int          roll;
        set_config(depth, transp);
        idle_on = idle;
        for (int n = 0; n < count; n++)
        begin
            mask = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0)
                mask = transp_now;
            roll = $urandom_range(0, 9);
            if (roll == 0)
                src = 16'h0000;
            else if (roll == 1)
                src = 16'hFFFF;
            else
                src = 16'($urandom_range(0, 65535));
            send_pixel(mask, 2'($urandom_range(0, 3)), $urandom_range(0, 9) != 0, src);
        end
    endtask

    // Random pixels across a spread of configurations, extremes included.
    task automatic test_random_configs();
        logic [1:0] depth;
        run_random_phase(DEPTH_8BIT, 8'hFF, 1'b1, RANDOM_PHASE_BEATS);
        run_random_phase(DEPTH_4BIT, 8'h00, 1'b1, RANDOM_PHASE_BEATS);
        run_random_phase(DEPTH_2BIT, 8'hFF, 1'b0, RANDOM_PHASE_BEATS);
        run_random_phase(2'd3, 8'h00, 1'b1, RANDOM_PHASE_BEATS);
        run_random_phase(DEPTH_2BIT, 8'h00, 1'b1, RANDOM_PHASE_BEATS);
        for (int p = 0; p < 5; p++)
        begin
            depth = 2'($urandom_range(0, 3));
            run_random_phase(depth, reachable_code(depth), p != 2, RANDOM_PHASE_BEATS);
        end
    endtask

    // Compare each result beat with the oldest owed pixel and pace m_tready.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (shade_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result beat: we=%0b pixel=%04h", m_tuser, m_tdata);
            end
            else
            begin
                owed_pix = shade_q.pop_front();
                if (m_tuser !== owed_pix.write_enable || m_tdata !== owed_pix.pixel_out)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"result mismatch: expected we=%0b pixel=%04h, ",
                                  "got we=%0b pixel=%04h"},
                                 owed_pix.write_enable, owed_pix.pixel_out, m_tuser, m_tdata);
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            stall_left = pick_gap();
            m_tready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_depth_modes();
        test_random_configs();
        drain_pipe();
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
